/* hw/rtl/ctp_pkg.sv */
// Countdown timer pool: shared types and constants.
// No dependencies; used by the interfaces, controller, datapath and top level.
package ctp_pkg;

	// Result status codes
	typedef enum logic [1:0] {
		ST_STARTED   = 2'd0,
		ST_NO_SLOT   = 2'd1,
		ST_TICK_DONE = 2'd2,
		ST_ZERO_WAIT = 2'd3
	} status_t;

	localparam int WAIT_W    = 32;
	localparam int RES_W     = 8;
	localparam int SLOT_IX_W = 3;
	localparam int MASK_W    = 8;
	localparam int DIV_STEPS = WAIT_W;
	localparam int DIV_CW    = $clog2(DIV_STEPS);

	// Controller -> datapath
	typedef struct packed {
		logic    load;      // latch request, reset divider and walk
		logic    div_step;  // one restoring-divide step
		logic    idx_inc;   // advance slot pointer
		logic    claim;     // load current slot with the tick count
		logic    tick_upd;  // decrement current slot if busy
		logic    out_load;  // move result into the output register
		status_t code;      // status of the result being loaded
	} cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic wait_zero;
		logic div_last;
		logic idx_last;
		logic cur_busy;
		logic out_free;
	} sts_t;

endpackage

/* hw/rtl/ctp_req_if.sv */
// Request channel of the countdown timer pool (valid/ready plus payload).
// Depends on ctp_pkg for field widths.
interface ctp_req_if;
	logic                         valid;
	logic                         ready;
	logic                         req_type;
	logic [ctp_pkg::WAIT_W-1:0]   wait_us;

	modport source (output valid, req_type, wait_us, input ready);
	modport sink   (input valid, req_type, wait_us, output ready);
endinterface

/* hw/rtl/ctp_rsp_if.sv */
// Result channel of the countdown timer pool (valid/ready plus payload).
// Depends on ctp_pkg for the status type and field widths.
interface ctp_rsp_if;
	logic                           valid;
	logic                           ready;
	ctp_pkg::status_t               status;
	logic [ctp_pkg::SLOT_IX_W-1:0]  slot_index;
	logic [ctp_pkg::MASK_W-1:0]     expired_mask;

	modport source (output valid, status, slot_index, expired_mask, input ready);
	modport sink   (input valid, status, slot_index, expired_mask, output ready);
endinterface

/* hw/rtl/countdown_timer_pool_unit.sv */
// Countdown timer pool, top level. One request in flight at a time.
// Start: accept, 32 divide steps (1 quotient bit per cycle), a search of up to
//   NUM_SLOTS slots, then hand-off. A zero wait skips the divide and the search.
// Tick: walks every slot, one per cycle, then hands off its result.
// Next request is taken while the previous result waits in the output register.
// arst_n clears all slots to free and sets resolution_us to 1.
module countdown_timer_pool_unit #(
	parameter int NUM_SLOTS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [ctp_pkg::RES_W-1:0]  cfg_wr_data,
	ctp_req_if.sink                    req,
	ctp_rsp_if.source                  rsp
);

	// controller/datapath handshake
	ctp_pkg::cmd_t cmd;
	ctp_pkg::sts_t sts;

	// The controller owns sequencing only; all arithmetic and slot
	// storage sits in the datapath.
	ctp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.in_type  (req.req_type),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Divider, slot counters, busy bits and result register.
	ctp_dp #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.in_wait          (req.wait_us),
		.cmd              (cmd),
		.sts              (sts),
		.out_valid        (rsp.valid),
		.out_ready        (rsp.ready),
		.out_status       (rsp.status),
		.out_slot_index   (rsp.slot_index),
		.out_expired_mask (rsp.expired_mask)
	);

`ifndef SYNTH
	// ready is dropped once a request is accepted
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while previous one in flight");

	// only ticks report expired slots
	a_mask_tick_only: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status != ctp_pkg::ST_TICK_DONE)) |-> (rsp.expired_mask == '0))
		else $error("expired mask set on a start result");

	// only a successful start names a slot
	a_index_start_only: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status != ctp_pkg::ST_STARTED)) |-> (rsp.slot_index == '0))
		else $error("slot index set on a non-start result");

	// result register is never overwritten while stalled
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!rsp.valid || rsp.ready))
		else $error("result loaded over an untaken result");
`endif

endmodule

/* hw/rtl/ctp_ctrl.sv */
// Countdown timer pool controller: sequences divide, slot search, tick walk
// and result hand-off. Depends on ctp_pkg (cmd_t, sts_t, status_t).
module ctp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             in_type,
	input  ctp_pkg::sts_t    sts,
	output ctp_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_SCAN,
		S_TICK,
		S_FIN
	} state_t;

	state_t           state_q;
	ctp_pkg::status_t code_q;
	logic             accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd          = '0;
		cmd.code     = code_q;
		cmd.load     = accept;
		cmd.div_step = (state_q == S_DIV) && !sts.wait_zero;
		cmd.claim    = (state_q == S_SCAN) && !sts.cur_busy;
		cmd.idx_inc  = ((state_q == S_SCAN) && sts.cur_busy && !sts.idx_last) ||
			((state_q == S_TICK) && !sts.idx_last);
		cmd.tick_upd = (state_q == S_TICK);
		cmd.out_load = (state_q == S_FIN) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= ctp_pkg::ST_STARTED;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= in_type ? S_TICK : S_DIV;
					end
				end
				S_DIV: begin
					if (sts.wait_zero) begin
						code_q  <= ctp_pkg::ST_ZERO_WAIT;
						state_q <= S_FIN;
					end else if (sts.div_last) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (!sts.cur_busy) begin
						code_q  <= ctp_pkg::ST_STARTED;
						state_q <= S_FIN;
					end else if (sts.idx_last) begin
						code_q  <= ctp_pkg::ST_NO_SLOT;
						state_q <= S_FIN;
					end
				end
				S_TICK: begin
					if (sts.idx_last) begin
						code_q  <= ctp_pkg::ST_TICK_DONE;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/ctp_dp.sv */
// Countdown timer pool datapath: resolution register, serial divider,
// slot counters with busy bits, and the result register. Depends on ctp_pkg.
module ctp_dp #(
	parameter int NUM_SLOTS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [ctp_pkg::RES_W-1:0]      cfg_wr_data,
	input  logic [ctp_pkg::WAIT_W-1:0]     in_wait,
	input  ctp_pkg::cmd_t                  cmd,
	output ctp_pkg::sts_t                  sts,
	output logic                           out_valid,
	input  logic                           out_ready,
	output ctp_pkg::status_t               out_status,
	output logic [ctp_pkg::SLOT_IX_W-1:0]  out_slot_index,
	output logic [ctp_pkg::MASK_W-1:0]     out_expired_mask
);

	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	logic [ctp_pkg::RES_W-1:0]   resolution_q;
	logic [ctp_pkg::RES_W-1:0]   res_q;
	logic [ctp_pkg::WAIT_W-1:0]  dvd_q;      // dividend in, quotient out
	logic [ctp_pkg::RES_W-1:0]   rem_q;
	logic [ctp_pkg::DIV_CW-1:0]  cnt_q;
	logic                        wait_zero_q;
	logic [IW-1:0]               idx_q;
	logic [ctp_pkg::MASK_W-1:0]  mask_q;
	logic [NUM_SLOTS-1:0]        busy_q;
	logic [ctp_pkg::WAIT_W-1:0]  slot_ticks_q [NUM_SLOTS];
	logic                        out_valid_q;

	logic [ctp_pkg::RES_W:0]     trial;
	logic                        trial_ge;
	logic [ctp_pkg::WAIT_W-1:0]  ticks;
	logic [ctp_pkg::WAIT_W-1:0]  cur_dec;

	assign trial    = {rem_q, dvd_q[ctp_pkg::WAIT_W-1]};
	assign trial_ge = trial >= {1'b0, res_q};
	// ceiling: bump the quotient when anything is left over
	assign ticks    = dvd_q + ctp_pkg::WAIT_W'(rem_q != '0);
	assign cur_dec  = slot_ticks_q[idx_q] - ctp_pkg::WAIT_W'(1);

	assign sts.wait_zero = wait_zero_q;
	assign sts.div_last  = (cnt_q == ctp_pkg::DIV_CW'(ctp_pkg::DIV_STEPS - 1));
	assign sts.idx_last  = (idx_q == IW'(NUM_SLOTS - 1));
	assign sts.cur_busy  = busy_q[idx_q];
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resolution_q <= ctp_pkg::RES_W'(1);
			busy_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				resolution_q <= cfg_wr_data;
			end
			if (cmd.claim) begin
				busy_q[idx_q] <= 1'b1;
			end else if (cmd.tick_upd && busy_q[idx_q] && (cur_dec == '0)) begin
				busy_q[idx_q] <= 1'b0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_q       <= (resolution_q == '0) ? ctp_pkg::RES_W'(1) : resolution_q;
			dvd_q       <= in_wait;
			rem_q       <= '0;
			cnt_q       <= '0;
			wait_zero_q <= (in_wait == '0);
			idx_q       <= '0;
			mask_q      <= '0;
		end else begin
			if (cmd.div_step) begin
				rem_q <= trial_ge ? ctp_pkg::RES_W'(trial - {1'b0, res_q})
					: ctp_pkg::RES_W'(trial);
				dvd_q <= {dvd_q[ctp_pkg::WAIT_W-2:0], trial_ge};
				cnt_q <= cnt_q + ctp_pkg::DIV_CW'(1);
			end
			if (cmd.idx_inc) begin
				idx_q <= idx_q + IW'(1);
			end
			if (cmd.tick_upd && busy_q[idx_q] && (cur_dec == '0)) begin
				// slots past the field width drop out of the shift
				mask_q <= mask_q | (ctp_pkg::MASK_W'(1) << idx_q);
			end
		end
		if (cmd.claim) begin
			slot_ticks_q[idx_q] <= ticks;
		end else if (cmd.tick_upd && busy_q[idx_q]) begin
			slot_ticks_q[idx_q] <= cur_dec;
		end
		if (cmd.out_load) begin
			out_status       <= cmd.code;
			out_slot_index   <= (cmd.code == ctp_pkg::ST_STARTED)
				? ctp_pkg::SLOT_IX_W'(idx_q) : '0;
			out_expired_mask <= (cmd.code == ctp_pkg::ST_TICK_DONE) ? mask_q : '0;
		end
	end

endmodule

/* tb/sv/tb_countdown_timer_pool_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench for countdown_timer_pool_unit: directed and random requests,
// a scoreboard class that predicts every result. Needs ctp_pkg, ctp_req_if and ctp_rsp_if.
module tb_countdown_timer_pool_unit;

	localparam int   SLOTS       = 8;
	localparam logic REQ_START   = 1'b0;
	localparam logic REQ_TICK    = 1'b1;
	localparam int   SEG_ITEMS   = 315;    // random requests per resolution setting
	localparam int   HOLD_CYCLES = 400;    // long result back-pressure stretch
	localparam int   QUIET_LIMIT = 4000;   // cycles with no handshake before giving up
	localparam int   SETTLE      = 8;      // idle cycles before a register write
	localparam int   TAIL        = 50;     // cycles left to run after the last result

	// One expected result
	typedef struct {
		ctp_pkg::status_t status;
		logic [2:0]       slot;
		logic [7:0]       mask;
	} pool_result_t;

	// Tracks the slot pool and the tick resolution, queues the result each request
	// must produce and compares the block's results against that queue in order.
	class timer_pool_scoreboard;
		logic [31:0]  ticks_left [SLOTS];
		bit           busy [SLOTS];
		logic [7:0]   res_us;
		pool_result_t expected_q [$];
		int errors, checked, starts, refused, zero_waits, ticks, expiries;

		function new();
			for (int k = 0; k < SLOTS; k++) begin
				ticks_left[k] = '0;
				busy[k]       = 1'b0;
			end
			res_us = 8'd1;
		endfunction

		function void set_resolution(logic [7:0] v);
			res_us = v;
		endfunction

		// A resolution of zero behaves as one microsecond per tick
		function int tick_res();
			return (res_us == 8'd0) ? 1 : int'(res_us);
		endfunction

		function bit pool_full();
			bit full;
			full = 1'b1;
			for (int k = 0; k < SLOTS; k++)
				if (!busy[k])
					full = 1'b0;
			return full;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_request(logic kind, logic [31:0] wait_us);
			pool_result_t r;
			logic [31:0]  div, q;
			bit           found;
			r.status = ctp_pkg::ST_TICK_DONE;
			r.slot   = '0;
			r.mask   = '0;
			found    = 1'b0;
			if (kind == REQ_START) begin
				div = tick_res();
				q   = wait_us / div;
				if (wait_us % div != 0)
					q = q + 1;
				if (q == 0) begin
					r.status = ctp_pkg::ST_ZERO_WAIT;
					zero_waits++;
				end else begin
					for (int k = 0; k < SLOTS; k++) begin
						if (!found && !busy[k]) begin
							found         = 1'b1;
							busy[k]       = 1'b1;
							ticks_left[k] = q;
							r.slot        = k[2:0];
						end
					end
					r.status = found ? ctp_pkg::ST_STARTED : ctp_pkg::ST_NO_SLOT;
					if (found)
						starts++;
					else
						refused++;
				end
			end else begin
				ticks++;
				for (int k = 0; k < SLOTS; k++) begin
					if (busy[k]) begin
						ticks_left[k] = ticks_left[k] - 1;
						if (ticks_left[k] == 0) begin
							busy[k]   = 1'b0;
							r.mask[k] = 1'b1;
							expiries++;
						end
					end
				end
			end
			expected_q.push_back(r);
		endfunction

		function void check_result(ctp_pkg::status_t st, logic [2:0] slot, logic [7:0] mask);
			pool_result_t e;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 20)
					$display("%0t: result with nothing expected: status %s slot %0d mask %02h",
						$time, st.name(), slot, mask);
				return;
			end
			e = expected_q.pop_front();
			checked++;
			if (st !== e.status) begin
				errors++;
				if (errors <= 20)
					$display("%0t: status expected %s actual %s", $time, e.status.name(),
						st.name());
			end
			if (slot !== e.slot) begin
				errors++;
				if (errors <= 20)
					$display("%0t: slot_index expected %0d actual %0d", $time, e.slot, slot);
			end
			if (mask !== e.mask) begin
				errors++;
				if (errors <= 20)
					$display("%0t: expired_mask expected %02h actual %02h", $time, e.mask, mask);
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [7:0] cfg_wr_data;

	ctp_req_if req_ch();
	ctp_rsp_if rsp_ch();

	countdown_timer_pool_unit #(
		.NUM_SLOTS(SLOTS)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req_ch),
		.rsp         (rsp_ch)
	);

	timer_pool_scoreboard sb;

	// Idle rates in percent, changed per phase by the stimulus
	int send_idle_pct = 8;
	int rcv_idle_pct  = 81;
	int hold_requests = 0;   // bumped by the stimulus to ask for a long result stall
	int quiet_cycles  = 0;
	int res_writes    = 0;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Result side: random ready, or a long hold-off when the stimulus asks for one.
	// The hold is counted here so the sender keeps offering requests meanwhile.
	initial begin : result_sink
		int taken;
		taken = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != taken) begin
				taken++;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
			end
		end
	end

	// Every accepted result goes to the scoreboard
	always @(posedge clk)
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_result(rsp_ch.status, rsp_ch.slot_index, rsp_ch.expired_mask);

	// Watchdog: a run of cycles without any handshake means the block hung
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no handshake for %0d cycles, %0d results outstanding",
				$time, QUIET_LIMIT, sb.pending());
			$display("** countdown_timer_pool_unit: FAILED **");
			$finish;
		end
	end

	// Offer one request and return at the edge that accepts it. valid stays high on
	// return; the caller's next action in the same step decides what it becomes.
	task automatic send_request(input logic kind, input logic [31:0] wait_us);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.wait_us  <= wait_us;
		do
			@(posedge clk);
		while (!req_ch.ready);
		sb.note_request(kind, wait_us);
	endtask

	// Drop valid right after an accept and sit until every result is back
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Register writes only happen with the pool idle
	task automatic write_resolution(input logic [7:0] v);
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_resolution(v);
		res_writes++;
	endtask

	// Mostly ticks and short starts so slots keep cycling; full-width waits only
	// when the pool is full, since a claimed slot that size would never expire.
	task automatic send_random_item();
		int          pick, r, target;
		logic [31:0] w;
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			send_request(REQ_TICK, $urandom());   // wait field is don't-care on ticks
		end else if (pick < 56) begin
			send_request(REQ_START, 32'd0);
		end else if (sb.pool_full() && pick < 72) begin
			send_request(REQ_START, $urandom());
		end else begin
			r      = sb.tick_res();
			target = $urandom_range(1, 10);
			w      = (target - 1) * r + $urandom_range(1, r);
			send_request(REQ_START, w);
		end
	endtask

	initial begin : stimulus
		logic [7:0] res_plan [6];
		// Everything the block sees is known from time zero
		arst_n          <= 1'b0;
		cfg_wr_en       <= 1'b0;
		cfg_wr_data     <= '0;
		req_ch.valid    <= 1'b0;
		req_ch.req_type <= REQ_START;
		req_ch.wait_us  <= '0;
		sb = new();
		res_plan = '{8'd1, 8'd255, 8'd0, 8'd1, 8'd128, 8'd1};
		res_plan[3] = $urandom_range(2, 254);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, at the reset resolution of one microsecond per tick
		send_request(REQ_TICK, 32'd0);            // tick with every slot free
		send_request(REQ_START, 32'd0);           // zero wait
		send_request(REQ_START, 32'd1);           // slot 0, one tick
		send_request(REQ_START, 32'd2);           // slot 1, two ticks
		send_request(REQ_START, 32'd3);           // slot 2, three ticks
		repeat (3) send_request(REQ_TICK, 32'd0); // each slot expires on its own tick
		for (int k = 0; k < SLOTS; k++)
			send_request(REQ_START, 32'd5);       // fill the pool
		send_request(REQ_START, 32'd7);           // refused, pool full
		send_request(REQ_START, 32'hFFFF_FFFF);   // widest wait, refused
		send_request(REQ_START, 32'd0);           // zero wait still done when full
		repeat (5) send_request(REQ_TICK, 32'hFFFF_FFFF); // all eight expire together

		// Largest resolution: rounding up at the tick boundaries
		write_resolution(8'd255);
		send_request(REQ_START, 32'd255);         // exactly one tick
		send_request(REQ_START, 32'd256);         // rounds up to two
		send_request(REQ_START, 32'd510);         // exactly two
		send_request(REQ_START, 32'd511);         // rounds up to three
		repeat (3) send_request(REQ_TICK, 32'd0);

		// Random part: two segments per idle phase, a new resolution for each
		for (int seg = 0; seg < 6; seg++) begin
			if (seg < 2) begin
				send_idle_pct = 8;
				rcv_idle_pct  = 81;
			end else if (seg < 4) begin
				send_idle_pct = 81;
				rcv_idle_pct  = 8;
			end else begin
				send_idle_pct = 0;
				rcv_idle_pct  = 0;
			end
			write_resolution(res_plan[seg]);
			for (int i = 0; i < SEG_ITEMS; i++) begin
				// Sender stops until the pool has answered everything
				if (seg == 2 && i == 150)
					wait_drained();
				// Long result stall while requests keep coming, so the input backs up
				if (seg == 4 && i == 100)
					hold_requests++;
				send_random_item();
			end
		end

		// One claim with the widest wait; free a slot for it first
		while (sb.pool_full())
			send_request(REQ_TICK, 32'd0);
		send_request(REQ_START, 32'hFFFF_FFFF);
		send_request(REQ_TICK, 32'd0);

		wait_drained();
		repeat (TAIL) @(posedge clk);

		$display("Run covered %0d results: %0d slot claims, %0d refusals, %0d zero waits,",
			sb.checked, sb.starts, sb.refused, sb.zero_waits);
		$display("%0d ticks with %0d slot expiries, over %0d resolution settings.",
			sb.ticks, sb.expiries, res_writes);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("** countdown_timer_pool_unit: PASSED **");
		else
			$display("** countdown_timer_pool_unit: FAILED **");
		$finish;
	end
endmodule
